>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the point-in-triangle block.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pit_pkg.sv
// Package for the point-in-triangle block: widths, payload structs, latency.
// No dependencies; used by pit_wide_mul, point_in_triangle_test_top and the bench.
package pit_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;
    localparam int DOT_BITS      = PROD_BITS + 2;
    localparam int WIDE_BITS     = 2 * DOT_BITS;
    localparam int NUM_BITS      = WIDE_BITS + 1;
    localparam int ALPHA_BITS    = NUM_BITS + 2;
    localparam int MUL_LIMB_BITS = 24;
    localparam int MUL_LATENCY   = 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
        logic signed [COORD_BITS-1:0] p_x;
        logic signed [COORD_BITS-1:0] p_y;
        logic signed [COORD_BITS-1:0] p_z;
    } pit_in_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } pit_out_t;

endpackage

>>> hdl/pit_wide_mul.sv
// Signed multiplier for wide operands, split into limb partial products
// over three enabled register stages. Depends on pit_pkg for default widths.
module pit_wide_mul #(
    parameter int OP_BITS   = pit_pkg::DOT_BITS,
    parameter int LIMB_BITS = pit_pkg::MUL_LIMB_BITS
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [OP_BITS-1:0]   a,
    input  logic signed [OP_BITS-1:0]   b,
    output logic signed [2*OP_BITS-1:0] p
);
    localparam int NLIMB    = (OP_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int EXT_BITS = NLIMB * LIMB_BITS;
    localparam int PP_BITS  = 2 * LIMB_BITS + 2;
    localparam int RES_BITS = 2 * OP_BITS;

    logic signed [EXT_BITS-1:0]  a_ext, b_ext;
    logic signed [LIMB_BITS:0]   a_limb [NLIMB];
    logic signed [LIMB_BITS:0]   b_limb [NLIMB];
    logic signed [PP_BITS-1:0]   pp_next [NLIMB][NLIMB];
    logic signed [PP_BITS-1:0]   pp_reg  [NLIMB][NLIMB];
    logic signed [RES_BITS-1:0]  row_next [NLIMB];
    logic signed [RES_BITS-1:0]  row_reg  [NLIMB];
    logic signed [RES_BITS-1:0]  p_next, p_reg;

    assign a_ext = EXT_BITS'(a);
    assign b_ext = EXT_BITS'(b);

    // Lower limbs are unsigned, the top limb carries the sign.
    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            if (i == NLIMB - 1) begin
                a_limb[i] = $signed({a_ext[EXT_BITS-1], a_ext[i*LIMB_BITS +: LIMB_BITS]});
                b_limb[i] = $signed({b_ext[EXT_BITS-1], b_ext[i*LIMB_BITS +: LIMB_BITS]});
            end else begin
                a_limb[i] = $signed({1'b0, a_ext[i*LIMB_BITS +: LIMB_BITS]});
                b_limb[i] = $signed({1'b0, b_ext[i*LIMB_BITS +: LIMB_BITS]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            for (int j = 0; j < NLIMB; j++) begin
                pp_next[i][j] = a_limb[i] * b_limb[j];
            end
        end
    end

    // Sums wrap modulo 2^RES_BITS; the true product always fits.
    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NLIMB; j++) begin
                row_next[i] = row_next[i] + (RES_BITS'(pp_reg[i][j]) <<< (LIMB_BITS * j));
            end
        end
    end

    always_comb begin
        p_next = '0;
        for (int i = 0; i < NLIMB; i++) begin
            p_next = p_next + (row_reg[i] <<< (LIMB_BITS * i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> hdl/point_in_triangle_test_top.sv
// Top level of the barycentric point-in-triangle test.
// Depends on pit_pkg, pit_wide_mul and assert_macros.svh.
//
// The block takes one beat per clock unless a finished result is held waiting
// and returns one result beat per input beat, in order. The depth is set by
// the six wide products of the dot terms: each runs through a limb
// multiplier of three register stages, behind the difference, product and
// dot-sum stages and ahead of the numerator and sign-test stages. The whole
// pipeline holds while a finished result waits; a one-beat skid register on
// the input keeps s_ready a registered signal. The test is exact: weights
// are compared as integer numerators against a non-negative denominator, a
// zero weight counts as inside, and a zero denominator reports degenerate
// with inside_res low.
`include "assert_macros.svh"

module point_in_triangle_test_top #(
    parameter int LIMB_BITS = pit_pkg::MUL_LIMB_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pit_pkg::pit_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pit_pkg::pit_out_t  m_data
);
    import pit_pkg::*;

    localparam int PIPE_DEPTH = 5 + MUL_LATENCY;

    logic                     adv, s_fire, in_valid;
    pit_in_t                  in_data;
    logic                     skid_full_reg, skid_full_next;
    pit_in_t                  skid_data_reg, skid_data_next;
    logic [PIPE_DEPTH-1:0]    vld_reg, vld_next;

    logic signed [COORD_BITS-1:0] in_a [3];
    logic signed [COORD_BITS-1:0] in_b [3];
    logic signed [COORD_BITS-1:0] in_c [3];
    logic signed [COORD_BITS-1:0] in_p [3];

    logic signed [DIFF_BITS-1:0]  e0_next [3], e1_next [3], q_next [3];
    logic signed [DIFF_BITS-1:0]  e0_reg [3], e1_reg [3], q_reg [3];
    logic signed [PROD_BITS-1:0]  p00_next [3], p01_next [3], p11_next [3];
    logic signed [PROD_BITS-1:0]  p02_next [3], p12_next [3];
    logic signed [PROD_BITS-1:0]  p00_reg [3], p01_reg [3], p11_reg [3];
    logic signed [PROD_BITS-1:0]  p02_reg [3], p12_reg [3];
    logic signed [DOT_BITS-1:0]   d00_next, d01_next, d11_next, d02_next, d12_next;
    logic signed [DOT_BITS-1:0]   d00_reg, d01_reg, d11_reg, d02_reg, d12_reg;
    logic signed [WIDE_BITS-1:0]  den_hi, den_lo, bn_hi, bn_lo, gn_hi, gn_lo;
    logic signed [NUM_BITS-1:0]   den_next, bn_next, gn_next;
    logic signed [NUM_BITS-1:0]   den_reg, bn_reg, gn_reg;
    logic signed [ALPHA_BITS-1:0] alpha_num;
    pit_out_t                     out_next, out_reg;

    // Advance the whole pipeline unless the result register is held.
    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready  = !skid_full_reg;
    assign s_fire   = s_valid && s_ready;
    assign in_valid = skid_full_reg || s_fire;
    assign in_data  = skid_full_reg ? skid_data_reg : s_data;

    always_comb begin
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (adv) begin
            skid_full_next = 1'b0;
        end else if (s_fire) begin
            skid_full_next = 1'b1;
            skid_data_next = s_data;
        end
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    always_comb begin
        in_a[0] = in_data.a_x; in_a[1] = in_data.a_y; in_a[2] = in_data.a_z;
        in_b[0] = in_data.b_x; in_b[1] = in_data.b_y; in_b[2] = in_data.b_z;
        in_c[0] = in_data.c_x; in_c[1] = in_data.c_y; in_c[2] = in_data.c_z;
        in_p[0] = in_data.p_x; in_p[1] = in_data.p_y; in_p[2] = in_data.p_z;
        for (int k = 0; k < 3; k++) begin
            e0_next[k] = DIFF_BITS'(in_b[k]) - DIFF_BITS'(in_a[k]);
            e1_next[k] = DIFF_BITS'(in_c[k]) - DIFF_BITS'(in_a[k]);
            q_next[k]  = DIFF_BITS'(in_p[k]) - DIFF_BITS'(in_a[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p00_next[k] = e0_reg[k] * e0_reg[k];
            p01_next[k] = e0_reg[k] * e1_reg[k];
            p11_next[k] = e1_reg[k] * e1_reg[k];
            p02_next[k] = e0_reg[k] * q_reg[k];
            p12_next[k] = e1_reg[k] * q_reg[k];
        end
    end

    always_comb begin
        d00_next = DOT_BITS'(p00_reg[0]) + DOT_BITS'(p00_reg[1]) + DOT_BITS'(p00_reg[2]);
        d01_next = DOT_BITS'(p01_reg[0]) + DOT_BITS'(p01_reg[1]) + DOT_BITS'(p01_reg[2]);
        d11_next = DOT_BITS'(p11_reg[0]) + DOT_BITS'(p11_reg[1]) + DOT_BITS'(p11_reg[2]);
        d02_next = DOT_BITS'(p02_reg[0]) + DOT_BITS'(p02_reg[1]) + DOT_BITS'(p02_reg[2]);
        d12_next = DOT_BITS'(p12_reg[0]) + DOT_BITS'(p12_reg[1]) + DOT_BITS'(p12_reg[2]);
    end

    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_den_hi (
        .aclk(aclk), .en(adv), .a(d00_reg), .b(d11_reg), .p(den_hi)
    );
    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_den_lo (
        .aclk(aclk), .en(adv), .a(d01_reg), .b(d01_reg), .p(den_lo)
    );
    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_bn_hi (
        .aclk(aclk), .en(adv), .a(d11_reg), .b(d02_reg), .p(bn_hi)
    );
    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_bn_lo (
        .aclk(aclk), .en(adv), .a(d12_reg), .b(d01_reg), .p(bn_lo)
    );
    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_gn_hi (
        .aclk(aclk), .en(adv), .a(d00_reg), .b(d12_reg), .p(gn_hi)
    );
    pit_wide_mul #(.OP_BITS(DOT_BITS), .LIMB_BITS(LIMB_BITS)) u_mul_gn_lo (
        .aclk(aclk), .en(adv), .a(d01_reg), .b(d02_reg), .p(gn_lo)
    );

    always_comb begin
        den_next = NUM_BITS'(den_hi) - NUM_BITS'(den_lo);
        bn_next  = NUM_BITS'(bn_hi) - NUM_BITS'(bn_lo);
        gn_next  = NUM_BITS'(gn_hi) - NUM_BITS'(gn_lo);
    end

    // Alpha numerator is den - beta - gamma; a zero weight counts as inside.
    always_comb begin
        alpha_num           = ALPHA_BITS'(den_reg) - ALPHA_BITS'(bn_reg)
                              - ALPHA_BITS'(gn_reg);
        out_next.degenerate = (den_reg == '0);
        out_next.inside_res = !out_next.degenerate && !bn_reg[NUM_BITS-1]
                              && !gn_reg[NUM_BITS-1] && !alpha_num[ALPHA_BITS-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
            vld_reg       <= '0;
        end else begin
            skid_full_reg <= skid_full_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        skid_data_reg <= skid_data_next;
        if (adv) begin
            e0_reg  <= e0_next;
            e1_reg  <= e1_next;
            q_reg   <= q_next;
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p11_reg <= p11_next;
            p02_reg <= p02_next;
            p12_reg <= p12_next;
            d00_reg <= d00_next;
            d01_reg <= d01_next;
            d11_reg <= d11_next;
            d02_reg <= d02_next;
            d12_reg <= d12_next;
            den_reg <= den_next;
            bn_reg  <= bn_next;
            gn_reg  <= gn_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[PIPE_DEPTH-1];
    assign m_data  = out_reg;

    `PIT_ASSERT_NOW(a_skid_only_behind_result, skid_full_reg, m_valid,
                    "skid beat held with no result waiting")
    `PIT_ASSERT_NOW(a_degenerate_not_inside, m_valid,
                    !(m_data.inside_res && m_data.degenerate),
                    "degenerate triangle reported inside")
    `PIT_ASSERT_NEXT(a_stall_holds_pipe, m_valid && !m_ready, $stable(vld_reg),
                     "pipeline valid bits moved during a stall")

endmodule

>>> bench/point_in_triangle_test_top_tb.sv
// Self-checking bench for point_in_triangle_test_top: a directed table, then random queries,
// scored by typed verdicts or an exact integer barycentric checker; needs pit_pkg, RTL only.
// Both channels idle at random; one long result stall and one full drain occur mid-run.
module point_in_triangle_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int     HALF_PERIOD  = 10;
    localparam int     RESET_CYCLES = 11;
    localparam int     RANDOM_ITEMS = 1880;
    localparam int     HOLD_AT      = 600;
    localparam int     PAUSE_AT     = 1200;
    localparam int     LONG_HOLD    = 400;
    localparam int     DRAIN_CYCLES = 32;
    localparam int     MAX_REPORTS  = 40;
    localparam longint WATCHDOG_NS  = 20_000_000;

    localparam pit_out_t VERDICT_INSIDE  = '{inside_res: 1'b1, degenerate: 1'b0};
    localparam pit_out_t VERDICT_OUTSIDE = '{inside_res: 1'b0, degenerate: 1'b0};
    localparam pit_out_t VERDICT_DEGEN   = '{inside_res: 1'b0, degenerate: 1'b1};

    // wide enough for every numerator at this coordinate width
    typedef logic signed [127:0] num_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vtx_t;

    typedef struct {
        pit_in_t  query;
        bit       typed;
        pit_out_t verdict;
    } query_row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pit_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    pit_out_t m_data;

    // side band that travels with s_data: a verdict typed into the table
    logic     drive_typed;
    pit_out_t drive_verdict;

    pit_out_t   pending_verdicts[$];
    query_row_t directed_rows[$];
    int         mismatches   = 0;
    int         results_seen = 0;
    int         hold_reqs    = 0;
    int         holds_done   = 0;

    point_in_triangle_test_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic num_t coord_at(pit_in_t t, int pnt, int axis);
        return num_t'($signed(t[(11 - 3 * pnt - axis) * COORD_BITS +: COORD_BITS]));
    endfunction

    function automatic pit_out_t classify_point(pit_in_t t);
        num_t     e0[3], e1[3], q[3];
        num_t     d00, d01, d11, d02, d12, den, bn, gn, an;
        pit_out_t r;
        for (int k = 0; k < 3; k++) begin
            e0[k] = coord_at(t, 1, k) - coord_at(t, 0, k);
            e1[k] = coord_at(t, 2, k) - coord_at(t, 0, k);
            q[k]  = coord_at(t, 3, k) - coord_at(t, 0, k);
        end
        d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
        d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
        d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
        d02 = e0[0] * q[0] + e0[1] * q[1] + e0[2] * q[2];
        d12 = e1[0] * q[0] + e1[1] * q[1] + e1[2] * q[2];
        den = d00 * d11 - d01 * d01;
        bn  = d11 * d02 - d12 * d01;
        gn  = d00 * d12 - d01 * d02;
        an  = den - bn - gn;
        r.degenerate = (den == '0);
        r.inside_res = !r.degenerate && !bn[127] && !gn[127] && !an[127];
        return r;
    endfunction

    function automatic vtx_t pt(int x, int y, int z);
        vtx_t v;
        v.x = x[COORD_BITS-1:0];
        v.y = y[COORD_BITS-1:0];
        v.z = z[COORD_BITS-1:0];
        return v;
    endfunction

    function automatic pit_in_t build_query(vtx_t a, vtx_t b, vtx_t c, vtx_t p);
        pit_in_t q;
        q.a_x = a.x; q.a_y = a.y; q.a_z = a.z;
        q.b_x = b.x; q.b_y = b.y; q.b_z = b.z;
        q.c_x = c.x; q.c_y = c.y; q.c_z = c.z;
        q.p_x = p.x; q.p_y = p.y; q.p_z = p.z;
        return q;
    endfunction

    function automatic query_row_t mk_row(vtx_t a, vtx_t b, vtx_t c, vtx_t p, bit typed,
                                          pit_out_t verdict);
        query_row_t row;
        row.query   = build_query(a, b, c, p);
        row.typed   = typed;
        row.verdict = verdict;
        return row;
    endfunction

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return srange(1, 3);
        if (r < 95) return srange(4, 8);
        return srange(15, 40);
    endfunction

    function automatic pit_in_t random_query();
        int pa[3], pb[3], pc[3], pp[3];
        int mode, pick, u, v, d, m;
        mode = $urandom_range(9);
        pick = $urandom_range(2);
        u    = $urandom_range(8);
        v    = $urandom_range(8 - u);
        m    = srange(-50, 50);
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0, 1, 2: begin
                    pa[k] = $urandom();
                    pb[k] = $urandom();
                    pc[k] = $urandom();
                    pp[k] = $urandom();
                end
                3, 4: begin
                    // tiny lattice: many exact zeros and flat triangles
                    pa[k] = srange(-12, 12);
                    pb[k] = srange(-12, 12);
                    pc[k] = srange(-12, 12);
                    pp[k] = srange(-12, 12);
                end
                5, 6: begin
                    // aim P at the triangle, near its edges now and then
                    pa[k] = srange(-3000, 3000);
                    pb[k] = srange(-3000, 3000);
                    pc[k] = srange(-3000, 3000);
                    pp[k] = pa[k] + (u * (pb[k] - pa[k]) + v * (pc[k] - pa[k])) / 8
                            + srange(-1, 1);
                end
                7: begin
                    d     = srange(-100, 100);
                    pa[k] = srange(-10000, 10000);
                    pb[k] = pa[k] + d;
                    pc[k] = pa[k] + m * d;
                    pp[k] = pa[k] + srange(-200, 200);
                end
                8: begin
                    pa[k] = $urandom();
                    pb[k] = (pick == 0) ? pa[k] : int'($urandom());
                    pc[k] = (pick == 1) ? pa[k] : ((pick == 2) ? pb[k] : int'($urandom()));
                    pp[k] = $urandom();
                end
                default: begin
                    pa[k] = $urandom();
                    pb[k] = $urandom();
                    pc[k] = $urandom();
                    pp[k] = ((pick == 0) ? pa[k] : ((pick == 1) ? pb[k] : pc[k]))
                            + srange(-3, 3);
                end
            endcase
        end
        return build_query(pt(pa[0], pa[1], pa[2]), pt(pb[0], pb[1], pb[2]),
                           pt(pc[0], pc[1], pc[2]), pt(pp[0], pp[1], pp[2]));
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // hold valid and payload until the beat is taken
    task automatic offer(input pit_in_t query, input bit typed, input pit_out_t verdict);
        s_valid       <= 1'b1;
        s_data        <= query;
        drive_typed   <= typed;
        drive_verdict <= verdict;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : score
        pit_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing pending",
                                            results_seen));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_data.inside_res !== want.inside_res)
                        flag_mismatch($sformatf("result %0d: inside_res %b, want %b",
                                                results_seen, m_data.inside_res,
                                                want.inside_res));
                    if (m_data.degenerate !== want.degenerate)
                        flag_mismatch($sformatf("result %0d: degenerate %b, want %b",
                                                results_seen, m_data.degenerate,
                                                want.degenerate));
                end
                results_seen++;
            end
            if (s_valid && s_ready)
                pending_verdicts.push_back(drive_typed ? drive_verdict : classify_point(s_data));
        end
    end

    initial begin : receiver
        int run_len, gap_len;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_reqs != holds_done) begin
                // stall long enough to back the pipeline up into s_ready
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else begin
                run_len = srange(1, 60);
                m_ready <= 1'b1;
                repeat (run_len) @(posedge aclk);
                gap_len = pick_gap();
                if (gap_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap_len) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        drive_typed   <= 1'b0;
        drive_verdict <= '0;

        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0),
                                       1'b1, VERDICT_DEGEN));
        directed_rows.push_back(mk_row(pt(32767, 32767, 32767), pt(32767, 32767, 32767),
                                       pt(32767, 32767, 32767), pt(32767, 32767, 32767),
                                       1'b1, VERDICT_DEGEN));
        directed_rows.push_back(mk_row(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                                       pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                                       1'b1, VERDICT_DEGEN));
        // collinear vertices
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(1, 1, 1), pt(2, 2, 2), pt(5, -3, 7),
                                       1'b1, VERDICT_DEGEN));
        directed_rows.push_back(mk_row(pt(3, 4, 5), pt(3, 4, 5), pt(9, 1, 2), pt(0, 0, 0),
                                       1'b1, VERDICT_DEGEN));
        directed_rows.push_back(mk_row(pt(-32768, -32768, -32768), pt(-2, -2, -2),
                                       pt(32764, 32764, 32764), pt(0, 0, 0),
                                       1'b1, VERDICT_DEGEN));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(10, 10, 0),
                                       1'b1, VERDICT_INSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(200, 200, 0), 1'b1, VERDICT_OUTSIDE));
        // P on a vertex: two weights exactly zero
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0), pt(0, 0, 0),
                                       1'b1, VERDICT_INSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(100, 0, 0), 1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(0, 100, 0), 1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(50, 50, 0), 1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(-1, 0, 0), 1'b0, VERDICT_OUTSIDE));
        // P far off the plane
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(100, 0, 0), pt(0, 100, 0),
                                       pt(10, 10, 30000), 1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(0, 100, 0), pt(100, 0, 0),
                                       pt(10, 10, 0), 1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(0, 0, 0), pt(10, 0, 10), pt(0, 10, 10), pt(3, 3, 6),
                                       1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(-32768, -32768, -32768), pt(32767, -32768, -32768),
                                       pt(-32768, 32767, -32768), pt(0, 0, -32768),
                                       1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(-32768, -32768, -32768), pt(32767, -32768, -32768),
                                       pt(-32768, 32767, -32768), pt(32767, 32767, 32767),
                                       1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(-32768, -32768, -32768), pt(32767, -32768, -32768),
                                       pt(-32768, 32767, -32768), pt(-32768, -32768, 32767),
                                       1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(32767, 32767, 32767), pt(-32768, 32767, -32768),
                                       pt(32767, -32768, -32768), pt(-32768, -32768, -32768),
                                       1'b0, VERDICT_OUTSIDE));
        directed_rows.push_back(mk_row(pt(21845, -21846, 21845), pt(-21846, 21845, -21846),
                                       pt(21845, 21845, -21846), pt(-21846, -21846, 21845),
                                       1'b0, VERDICT_OUTSIDE));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].query, directed_rows[i].typed, directed_rows[i].verdict);
            idle_sender(pick_gap());
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) hold_reqs <= hold_reqs + 1;
            if (n == PAUSE_AT) wait_drained();
            offer(random_query(), 1'b0, VERDICT_OUTSIDE);
            idle_sender(pick_gap());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("TIMEOUT: %0d results seen, %0d pending", results_seen,
                 pending_verdicts.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
